// ----- hdl/cbf_pkg.sv -----
// Shared types and constants for the cubic Bezier flattener.
// Used by every module under hdl/ but cbf_fifo and cbf_props; depends on nothing else.
package cbf_pkg;

    localparam int CoordW  = 16;
    localparam int NumCtrl = 4;
    localparam int SegW    = 6;
    localparam int TW      = 17;   // t in Q0.16 plus one bit so that t = 1.0 fits
    localparam int OutW    = 24;

    localparam logic [SegW-1:0] MaxSegments = 6'd63;
    localparam logic [SegW-1:0] SegResetVal = 6'd16;
    localparam logic [TW-1:0]   OneQ16      = 17'h10000;
    localparam logic [OutW-1:0] OutMax      = 24'h7FFFFF;
    localparam logic [OutW-1:0] OutMin      = 24'h800000;

    localparam int JobDepth = 2;
    localparam int OutDepth = 16;

    // index 0 is the start point, 3 the end point
    typedef struct packed {
        logic [NumCtrl-1:0][CoordW-1:0] x;
        logic [NumCtrl-1:0][CoordW-1:0] y;
    } ctrl_pts_t;

    typedef struct packed {
        ctrl_pts_t       pts;
        logic [SegW-1:0] nseg;     // clamped segment count
        logic [TW-1:0]   step_q;   // 65536 / nseg
        logic [SegW-1:0] step_r;   // 65536 % nseg
    } job_t;

    typedef struct packed {
        logic          valid;
        logic          last;
        logic [TW-1:0] t;
    } pt_cmd_t;

    typedef struct packed {
        logic            last;
        logic [OutW-1:0] x;
        logic [OutW-1:0] y;
    } result_t;

endpackage

// ----- hdl/cbf_front.sv -----
// Front end: accepts a curve, clamps the segment count and divides 65536
// by it (two quotient bits per cycle). Depends on cbf_pkg.
module cbf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  cbf_pkg::ctrl_pts_t          pts_in,
    input  logic                        cfg_we,
    input  logic [cbf_pkg::SegW-1:0]    cfg_data,
    output logic                        job_valid,
    input  logic                        job_ready,
    output cbf_pkg::job_t               job
);

    localparam int DivSteps = 9;

    typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_SEND} state_t;

    state_t                      state_reg;
    logic [cbf_pkg::SegW-1:0]    seg_count_reg;
    logic [3:0]                  step_cnt_reg;

    cbf_pkg::ctrl_pts_t          pts_reg;
    logic [cbf_pkg::SegW-1:0]    nseg_reg;
    logic [cbf_pkg::TW-1:0]      quo_reg;
    logic [cbf_pkg::SegW-1:0]    rem_reg;

    logic [cbf_pkg::SegW-1:0]    nseg_next;
    logic [cbf_pkg::SegW:0]      trial_hi;
    logic [cbf_pkg::SegW:0]      trial_lo;
    logic                        bit_hi;
    logic                        bit_lo;
    logic [cbf_pkg::SegW-1:0]    rem_mid;
    logic [cbf_pkg::SegW-1:0]    rem_next;
    logic [cbf_pkg::TW-1:0]      quo_next;
    logic                        accept;

    assign accept    = (state_reg == ST_IDLE) && push;
    assign full      = (state_reg != ST_IDLE);
    assign job_valid = (state_reg == ST_SEND);

    always_comb
    begin
        if (seg_count_reg == '0)
            nseg_next = cbf_pkg::SegW'(1);
        else if (seg_count_reg > cbf_pkg::MaxSegments)
            nseg_next = cbf_pkg::MaxSegments;
        else
            nseg_next = seg_count_reg;
    end

    // Dividend is 1 << 16; only the low bit of the first step is set.
    always_comb
    begin
        trial_hi = {rem_reg, 1'b0};
        bit_hi   = (trial_hi >= {1'b0, nseg_reg});
        rem_mid  = bit_hi ? cbf_pkg::SegW'(trial_hi - {1'b0, nseg_reg})
                          : trial_hi[cbf_pkg::SegW-1:0];
        trial_lo = {rem_mid, (step_cnt_reg == '0)};
        bit_lo   = (trial_lo >= {1'b0, nseg_reg});
        rem_next = bit_lo ? cbf_pkg::SegW'(trial_lo - {1'b0, nseg_reg})
                          : trial_lo[cbf_pkg::SegW-1:0];
        quo_next = {quo_reg[cbf_pkg::TW-3:0], bit_hi, bit_lo};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_count_reg <= cbf_pkg::SegResetVal;
            step_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                seg_count_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    if (push)
                    begin
                        state_reg    <= ST_DIVIDE;
                        step_cnt_reg <= '0;
                    end
                end
                ST_DIVIDE:
                begin
                    step_cnt_reg <= step_cnt_reg + 4'd1;
                    if (step_cnt_reg == 4'(DivSteps - 1))
                        state_reg <= ST_SEND;
                end
                ST_SEND:
                begin
                    if (job_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pts_reg  <= pts_in;
            nseg_reg <= nseg_next;
            quo_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign job.pts    = pts_reg;
    assign job.nseg   = nseg_reg;
    assign job.step_q = quo_reg;
    assign job.step_r = rem_reg;

endmodule

// ----- hdl/cbf_fifo.sv -----
// Small synchronous queue built from registers, one write and one read port.
// Stand-alone; used for the job queue and the result queue.
module cbf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             wr_fire;
    logic             rd_fire;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_fire)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (rd_fire)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_reg + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- hdl/cbf_seq.sv -----
// Back-end sequencer: steps t across one curve, one point per cycle, and
// holds issue while the result queue has no room. Depends on cbf_pkg.
module cbf_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  cbf_pkg::job_t        job,
    output logic                 job_pop,
    input  logic                 result_pop,
    output cbf_pkg::pt_cmd_t     cmd,
    output cbf_pkg::ctrl_pts_t   pts
);

    localparam int PW = $clog2(cbf_pkg::OutDepth) + 1;

    logic                        active_reg;
    logic [PW-1:0]               pending_reg;
    logic [cbf_pkg::SegW-1:0]    idx_reg;
    cbf_pkg::job_t               job_reg;
    logic [cbf_pkg::TW-1:0]      t_reg;
    logic [cbf_pkg::SegW-1:0]    rem_reg;

    logic                        can_issue;
    logic                        is_last;
    logic [cbf_pkg::SegW:0]      rem_sum;
    logic                        wrap;
    logic [cbf_pkg::SegW-1:0]    rem_step;
    logic [cbf_pkg::TW-1:0]      t_step;

    assign can_issue = active_reg && (pending_reg < PW'(cbf_pkg::OutDepth));
    assign is_last   = (idx_reg == job_reg.nseg);
    assign job_pop   = job_valid && (!active_reg || (can_issue && is_last));

    assign cmd.valid = can_issue;
    assign cmd.last  = is_last;
    assign cmd.t     = is_last ? cbf_pkg::OneQ16 : t_reg;
    assign pts       = job_reg.pts;

    // t(i) = round(i * 65536 / n): add quotient, carry when remainder wraps
    always_comb
    begin
        rem_sum  = {1'b0, rem_reg} + {1'b0, job_reg.step_r};
        wrap     = (rem_sum >= {1'b0, job_reg.nseg});
        rem_step = wrap ? cbf_pkg::SegW'(rem_sum - {1'b0, job_reg.nseg})
                        : rem_sum[cbf_pkg::SegW-1:0];
        t_step   = t_reg + job_reg.step_q + cbf_pkg::TW'(wrap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pending_reg <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (job_pop)
                active_reg <= 1'b1;
            else if (can_issue && is_last)
                active_reg <= 1'b0;

            if (job_pop)
                idx_reg <= '0;
            else if (can_issue)
                idx_reg <= idx_reg + cbf_pkg::SegW'(1);

            pending_reg <= pending_reg + PW'(can_issue) - PW'(result_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
            t_reg   <= '0;
            rem_reg <= job.nseg >> 1;
        end
        else if (can_issue)
        begin
            t_reg   <= t_step;
            rem_reg <= rem_step;
        end
    end

endmodule

// ----- hdl/cbf_blend.sv -----
// Seven-stage Bernstein blend: weights from t, weighted sum of the four
// control points, rounding and saturation. Depends on cbf_pkg.
module cbf_blend #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbf_pkg::pt_cmd_t     cmd,
    input  cbf_pkg::ctrl_pts_t   pts,
    output logic                 out_valid,
    output cbf_pkg::result_t     result
);

    localparam int Stages = 7;
    localparam int RW     = 16 + FRAC_BITS;
    localparam int LoBit  = 48 - FRAC_BITS;
    localparam int SW     = (RW + 1 > 25) ? RW + 1 : 25;
    localparam logic [63:0]          RoundHalf = 64'd1 << (47 - FRAC_BITS);
    localparam logic [SW-1:0]        Offset    = SW'(32768) << FRAC_BITS;
    localparam logic signed [SW-1:0] SatHi     = (SW'(1) << 23) - SW'(1);
    localparam logic signed [SW-1:0] SatLo     = -(SW'(1) << 23);

    logic [Stages-1:0]      vld_reg;
    logic [Stages-1:0]      last_reg;

    // stage 1
    logic [1:0][3:0][15:0]  u1_reg;
    logic [16:0]            t1_reg;
    logic [16:0]            q1_reg;
    logic [33:0]            qq1_reg;
    logic [33:0]            tt1_reg;
    // stages 2 and 3
    logic [1:0][3:0][15:0]  u2_reg;
    logic [1:0][3:0][15:0]  u3_reg;
    logic [3:0][48:0]       m2_reg;
    logic [3:0][48:0]       w3_reg;
    // stages 4 to 7
    logic [1:0][3:0][40:0]  ph4_reg;
    logic [1:0][3:0][39:0]  pl4_reg;
    logic [1:0][39:0]       hs5_reg;
    logic [1:0][41:0]       ls5_reg;
    logic [1:0][RW-1:0]     r6_reg;
    logic [1:0][23:0]       out7_reg;

    logic [1:0][3:0][15:0]  u_in;
    logic [16:0]            q_in;
    logic [3:0][50:0]       prod2;
    logic [1:0][63:0]       acc6;
    logic [1:0][SW-1:0]     v7;
    logic [1:0][23:0]       sat7;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            // offset binary: p + 32768
            u_in[0][k] = {~pts.x[k][15], pts.x[k][14:0]};
            u_in[1][k] = {~pts.y[k][15], pts.y[k][14:0]};
        end
        q_in = cbf_pkg::OneQ16 - cmd.t;
    end

    always_comb
    begin
        prod2[0] = 51'(qq1_reg) * 51'(q1_reg);
        prod2[1] = 51'(qq1_reg) * 51'(t1_reg);
        prod2[2] = 51'(tt1_reg) * 51'(q1_reg);
        prod2[3] = 51'(tt1_reg) * 51'(t1_reg);
    end

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            acc6[a] = {hs5_reg[a], 24'd0} + 64'(ls5_reg[a]) + RoundHalf;
            v7[a]   = SW'(r6_reg[a]) - Offset;
            if ($signed(v7[a]) > SatHi)
                sat7[a] = cbf_pkg::OutMax;
            else if ($signed(v7[a]) < SatLo)
                sat7[a] = cbf_pkg::OutMin;
            else
                sat7[a] = v7[a][23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[Stages-2:0], cmd.valid};
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[Stages-2:0], cmd.last};

        u1_reg  <= u_in;
        t1_reg  <= cmd.t;
        q1_reg  <= q_in;
        qq1_reg <= 34'(q_in) * 34'(q_in);
        tt1_reg <= 34'(cmd.t) * 34'(cmd.t);

        u2_reg <= u1_reg;
        for (int k = 0; k < 4; k++)
            m2_reg[k] <= prod2[k][48:0];

        u3_reg    <= u2_reg;
        w3_reg[0] <= m2_reg[0];
        w3_reg[1] <= m2_reg[1] + {m2_reg[1][47:0], 1'b0};
        w3_reg[2] <= m2_reg[2] + {m2_reg[2][47:0], 1'b0};
        w3_reg[3] <= m2_reg[3];

        for (int a = 0; a < 2; a++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ph4_reg[a][k] <= 41'(w3_reg[k][48:24]) * 41'(u3_reg[a][k]);
                pl4_reg[a][k] <= 40'(w3_reg[k][23:0]) * 40'(u3_reg[a][k]);
            end
            hs5_reg[a] <= 40'(ph4_reg[a][0]) + 40'(ph4_reg[a][1])
                        + 40'(ph4_reg[a][2]) + 40'(ph4_reg[a][3]);
            ls5_reg[a] <= 42'(pl4_reg[a][0]) + 42'(pl4_reg[a][1])
                        + 42'(pl4_reg[a][2]) + 42'(pl4_reg[a][3]);
            r6_reg[a]   <= acc6[a][LoBit +: RW];
            out7_reg[a] <= sat7[a];
        end
    end

    assign out_valid   = vld_reg[Stages-1];
    assign result.last = last_reg[Stages-1];
    assign result.x    = out7_reg[0];
    assign result.y    = out7_reg[1];

endmodule

// ----- hdl/cubic_bezier_flattener.sv -----
// Top level of the cubic Bezier flattener: front end, job queue, sequencer,
// blend pipeline and result queue. Depends on cbf_pkg and the cbf_* modules.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+-----------------------------
//  curve in  | in        | push / full           | start_*, ctrl_a_*, ctrl_b_*, end_*
//  point out | out       | pop / empty           | point_x, point_y, last_point
//  config    | in        | segment_count_we      | segment_count_wdata
//
// Back end: n+1 points per curve of n segments (17 at the reset count), one point per cycle
// while issue is not held. Front end: takes a curve, divides 65536 by n, hands on the job;
// a two-entry job queue lets it run ahead.
// Reset is asynchronous; the segment count returns to 16.
// Issue holds once 16 points sit in the blend pipeline and the 16-entry result queue
// together, so pop may stall for any length of time.
module cubic_bezier_flattener #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [15:0] ctrl_a_x,
    input  logic [15:0] ctrl_a_y,
    input  logic [15:0] ctrl_b_x,
    input  logic [15:0] ctrl_b_y,
    input  logic [15:0] end_x,
    input  logic [15:0] end_y,
    input  logic        segment_count_we,
    input  logic [5:0]  segment_count_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] point_x,
    output logic [23:0] point_y,
    output logic        last_point
);

    cbf_pkg::ctrl_pts_t pts_in;
    cbf_pkg::ctrl_pts_t seq_pts;
    cbf_pkg::job_t      front_job;
    cbf_pkg::job_t      queue_job;
    cbf_pkg::pt_cmd_t   cmd;
    cbf_pkg::result_t   blend_result;
    cbf_pkg::result_t   head_result;
    logic               front_valid;
    logic               job_full;
    logic               job_empty;
    logic               job_pop;
    logic               blend_valid;
    logic               result_pop;

    assign pts_in.x   = {end_x, ctrl_b_x, ctrl_a_x, start_x};
    assign pts_in.y   = {end_y, ctrl_b_y, ctrl_a_y, start_y};
    assign result_pop = pop && !empty;

    cbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pts_in    (pts_in),
        .cfg_we    (segment_count_we),
        .cfg_data  (segment_count_wdata),
        .job_valid (front_valid),
        .job_ready (!job_full),
        .job       (front_job)
    );

    cbf_fifo #(
        .WIDTH ($bits(cbf_pkg::job_t)),
        .DEPTH (cbf_pkg::JobDepth)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_job),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (queue_job),
        .empty   (job_empty)
    );

    cbf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (!job_empty),
        .job        (queue_job),
        .job_pop    (job_pop),
        .result_pop (result_pop),
        .cmd        (cmd),
        .pts        (seq_pts)
    );

    cbf_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pts       (seq_pts),
        .out_valid (blend_valid),
        .result    (blend_result)
    );

    // room is reserved by the sequencer before issue, so writes never drop
    cbf_fifo #(
        .WIDTH ($bits(cbf_pkg::result_t)),
        .DEPTH (cbf_pkg::OutDepth)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (blend_valid),
        .wr_data (blend_result),
        .full    (),
        .rd_en   (pop),
        .rd_data (head_result),
        .empty   (empty)
    );

    assign point_x    = head_result.x;
    assign point_y    = head_result.y;
    assign last_point = head_result.last;

endmodule

// ----- hdl/cbf_props.sv -----
// Port-level checks for the cubic Bezier flattener, bound to the top level.
// Depends only on the ports of cubic_bezier_flattener.
module cbf_props (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic [23:0] point_x,
    input logic [23:0] point_y,
    input logic        last_point
);

    logic [7:0] curves_open_reg;
    logic       in_fire;
    logic       last_fire;

    assign in_fire   = push && !full;
    assign last_fire = pop && !empty && last_point;

    // count curves accepted whose final point has not yet been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            curves_open_reg <= '0;
        else
            curves_open_reg <= curves_open_reg + 8'(in_fire) - 8'(last_fire);
    end

    a_no_result_without_curve: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (curves_open_reg != 8'd0))
        else $error("result shown with no curve outstanding");

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> full)
        else $error("front end did not go busy after accepting a curve");

    a_head_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(point_x) && $stable(point_y)
                              && $stable(last_point)))
        else $error("waiting result changed or vanished without pop");

endmodule

bind cubic_bezier_flattener cbf_props u_props (.*);

// ----- tb/cubic_bezier_flattener_tb.sv -----
// Self-checking testbench for cubic_bezier_flattener: a directed curve table, then
// random curves under several idle/stall mixes, checked against a local predictor (typed
// rows give first and last points by hand). Depends on cbf_pkg and the RTL under hdl/.
module cubic_bezier_flattener_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FracBits    = 8;
    localparam int DrainCycles = 40;
    localparam int RandomItems = 42;   // per idling phase

    typedef struct packed {
        int                       seg;          // -1 keeps the current count
        logic [15:0]              p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y;
        bit                       typed;        // first and last point given by hand
        logic [cbf_pkg::OutW-1:0] first_x, first_y, last_x, last_y;
    } curve_row_t;

    localparam int NumRows = 14;
    localparam curve_row_t CurveRows [NumRows] = '{
        '{-1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, 24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{-1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
          1'b1, 24'h7FFF00, 24'h7FFF00, 24'h7FFF00, 24'h7FFF00},
        '{-1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
          1'b1, 24'h800000, 24'h800000, 24'h800000, 24'h800000},
        '{-1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
          1'b1, 24'h7FFF00, 24'h800000, 24'h800000, 24'h7FFF00},
        '{0, 16'h0001, 16'hFFFF, 16'h1234, 16'hEDCB, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
          1'b1, 24'h000100, 24'hFFFF00, 24'hFFFF00, 24'h000100},
        '{1, 16'h0100, 16'hFF00, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0200, 16'hFE00,
          1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{63, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
          1'b1, 24'h800000, 24'h800000, 24'h7FFF00, 24'h7FFF00},
        '{-1, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
          1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{2, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
          1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{3, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
          1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{7, 16'h0001, 16'h0002, 16'hFFFE, 16'hFFFD, 16'h0003, 16'hFFFC, 16'h7FFE, 16'h8001,
          1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{62, 16'h1F3A, 16'hC2D1, 16'h8E07, 16'h64B9, 16'h0F0F, 16'hF0F0, 16'hA5C3, 16'h3C5A,
          1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{16, 16'h3FFF, 16'hC000, 16'hC000, 16'h3FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hBFFF,
          1'b1, 24'h3FFF00, 24'hC00000, 24'h400000, 24'hBFFF00},
        '{-1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00}
    };

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [15:0]              start_x = '0, start_y = '0, ctrl_a_x = '0, ctrl_a_y = '0;
    logic [15:0]              ctrl_b_x = '0, ctrl_b_y = '0, end_x = '0, end_y = '0;
    logic                     segment_count_we = 1'b0;
    logic [cbf_pkg::SegW-1:0] segment_count_wdata = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [cbf_pkg::OutW-1:0] point_x, point_y;
    logic                     last_point;

    cbf_pkg::result_t         pending_points [$];
    logic [cbf_pkg::SegW-1:0] seg_now = cbf_pkg::SegResetVal;
    int                       errors = 0;
    int unsigned              send_idle_pct = 0;
    int unsigned              pop_stall_pct = 0;

    cubic_bezier_flattener #(.FRAC_BITS(FracBits)) i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .start_x             (start_x),
        .start_y             (start_y),
        .ctrl_a_x            (ctrl_a_x),
        .ctrl_a_y            (ctrl_a_y),
        .ctrl_b_x            (ctrl_b_x),
        .ctrl_b_y            (ctrl_b_y),
        .end_x               (end_x),
        .end_y               (end_y),
        .segment_count_we    (segment_count_we),
        .segment_count_wdata (segment_count_wdata),
        .empty               (empty),
        .pop                 (pop),
        .point_x             (point_x),
        .point_y             (point_y),
        .last_point          (last_point)
    );

    always #1 clk = ~clk;

    function automatic logic [cbf_pkg::OutW-1:0] clip24(input longint v);
        if (v > 64'sd8388607)
            return cbf_pkg::OutMax;
        if (v < -64'sd8388608)
            return cbf_pkg::OutMin;
        return v[cbf_pkg::OutW-1:0];
    endfunction

    // Weighted sum of four coordinates, weights in Q0.48 summing to 2^48
    function automatic logic [cbf_pkg::OutW-1:0] bernstein_mix(
        input longint unsigned w [4],
        input logic [cbf_pkg::NumCtrl-1:0][cbf_pkg::CoordW-1:0] p);
        longint unsigned acc;
        longint unsigned r;
        acc = 0;
        // p + 32768 is the coordinate with its sign bit flipped
        for (int k = 0; k < 4; k++)
            acc += w[k] * longint'(p[k] ^ 16'h8000);
        acc += 64'd1 << (47 - FracBits);
        r = acc >> (48 - FracBits);
        return clip24(longint'(r) - (longint'(32768) << FracBits));
    endfunction

    function automatic void flatten_curve(input cbf_pkg::ctrl_pts_t c,
                                          input logic [cbf_pkg::SegW-1:0] seg);
        int unsigned      n;
        longint unsigned  t, q;
        longint unsigned  w [4];
        cbf_pkg::result_t pt;
        n = seg;
        if (n < 1)
            n = 1;
        if (n > cbf_pkg::MaxSegments)
            n = cbf_pkg::MaxSegments;
        for (int unsigned i = 0; i < n; i++)
        begin
            t = (longint'(i) * 65536 + n / 2) / n;
            q = 65536 - t;
            w[0] = q * q * q;
            w[1] = 3 * q * q * t;
            w[2] = 3 * q * t * t;
            w[3] = t * t * t;
            pt.x    = bernstein_mix(w, c.x);
            pt.y    = bernstein_mix(w, c.y);
            pt.last = 1'b0;
            pending_points.push_back(pt);
        end
        pt.x    = clip24(longint'($signed(c.x[3])) <<< FracBits);
        pt.y    = clip24(longint'($signed(c.y[3])) <<< FracBits);
        pt.last = 1'b1;
        pending_points.push_back(pt);
    endfunction

    // Offer one curve; predict its points at the edge that takes it
    task automatic send_curve(input cbf_pkg::ctrl_pts_t c, output int first_idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        start_x  <= c.x[0];
        start_y  <= c.y[0];
        ctrl_a_x <= c.x[1];
        ctrl_a_y <= c.y[1];
        ctrl_b_x <= c.x[2];
        ctrl_b_y <= c.y[2];
        end_x    <= c.x[3];
        end_y    <= c.y[3];
        do
            @(posedge clk);
        while (full);
        first_idx = pending_points.size();
        flatten_curve(c, seg_now);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    // Change the count only once the block has gone quiet
    task automatic set_segments(input logic [cbf_pkg::SegW-1:0] v);
        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        segment_count_we    <= 1'b1;
        segment_count_wdata <= v;
        @(posedge clk);
        segment_count_we <= 1'b0;
        seg_now = v;
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            3: return 16'($signed($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [cbf_pkg::SegW-1:0] pick_segments();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return cbf_pkg::MaxSegments;
        if (r < 30)
            return cbf_pkg::SegW'(1);
        return cbf_pkg::SegW'($urandom_range(20, 2));
    endfunction

    // Result side: check on every accepted point, then pick the next pop
    always @(posedge clk)
    begin
        cbf_pkg::result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_points.size() == 0)
                begin
                    $display("%0t: unexpected point x=%h y=%h last=%b",
                             $time, point_x, point_y, last_point);
                    errors++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (point_x !== want.x)
                    begin
                        $display("%0t: point_x expected %h got %h", $time, want.x, point_x);
                        errors++;
                    end
                    if (point_y !== want.y)
                    begin
                        $display("%0t: point_y expected %h got %h", $time, want.y, point_y);
                        errors++;
                    end
                    if (last_point !== want.last)
                    begin
                        $display("%0t: last_point expected %b got %b",
                                 $time, want.last, last_point);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("cubic_bezier_flattener_tb NOT OK");
        $finish;
    end

    initial
    begin
        cbf_pkg::ctrl_pts_t c;
        curve_row_t         row;
        int                 idx;
        int                 left;
        int                 group;
        int unsigned        idle_mix [4];
        int unsigned        stall_mix [4];
        idle_mix  = '{0, 78, 0, 38};
        stall_mix = '{0, 0, 78, 38};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NumRows; r++)
        begin
            row = CurveRows[r];
            if (row.seg >= 0)
                set_segments(cbf_pkg::SegW'(row.seg));
            c.x = {row.p4x, row.p3x, row.p2x, row.p1x};
            c.y = {row.p4y, row.p3y, row.p2y, row.p1y};
            send_curve(c, idx);
            if (row.typed)
            begin
                pending_points[idx].x = row.first_x;
                pending_points[idx].y = row.first_y;
                pending_points[pending_points.size() - 1].x = row.last_x;
                pending_points[pending_points.size() - 1].y = row.last_y;
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_mix[ph];
            pop_stall_pct = stall_mix[ph];
            left = RandomItems;
            while (left > 0)
            begin
                group = $urandom_range(10, 3);
                if (group > left)
                    group = left;
                set_segments(pick_segments());
                repeat (group)
                begin
                    for (int k = 0; k < cbf_pkg::NumCtrl; k++)
                    begin
                        c.x[k] = pick_coord();
                        c.y[k] = pick_coord();
                    end
                    send_curve(c, idx);
                end
                left -= group;
            end
        end

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0 && pending_points.size() == 0)
            $display("cubic_bezier_flattener_tb OK");
        else
            $display("cubic_bezier_flattener_tb NOT OK");
        $finish;
    end

endmodule
